// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers; compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// expr holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("%m: assertion failed");
// cons holds in the same cycle as ante
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- hdl/slcf_pkg.sv -----
// ----------------------------------------------------------------------------
// slcf_pkg
// Types and constants shared by the serial LCD command framer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package slcf_pkg;

    typedef enum logic [1:0] {
        OP_PRINT      = 2'd0,
        OP_GOTO       = 2'd1,
        OP_CLEAR      = 2'd2,
        OP_CLEAR_LINE = 2'd3
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] value;
    } t_cmd;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic [9:0] uart_frame;
        logic       last;
    } t_result;

    // work item handed from the front to the back
    typedef struct packed {
        logic       has_prefix;
        logic       spaces;
        logic [7:0] byte2;
    } t_desc;

    typedef enum logic [1:0] {
        ST_PREFIX = 2'd0,
        ST_BYTE   = 2'd1,
        ST_SPACE  = 2'd2
    } t_step;

    localparam logic [7:0] CMD_PREFIX  = 8'hFE;
    localparam logic [7:0] CURSOR_BASE = 8'h80;
    localparam logic [7:0] LINE2_BASE  = 8'hC0;
    localparam logic [7:0] CLEAR_CODE  = 8'h01;
    localparam logic [7:0] SPACE_CHAR  = 8'h20;
    localparam logic [7:0] LINE2_NUM   = 8'd2;

    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    function automatic t_result make_result(input logic [7:0] b, input logic fin);
        t_result r;
        r.tx_byte    = b;
        r.uart_frame = {1'b1, b, 1'b0};
        r.last       = fin;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/slcf_queue.sv -----
// ----------------------------------------------------------------------------
// slcf_queue
// Short descriptor queue between the command front and the byte sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module slcf_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_wr,
    input  wire slcf_pkg::t_desc i_desc,
    output logic                o_full,
    input  wire logic           i_rd,
    output logic                o_empty,
    output slcf_pkg::t_desc     o_desc
);

    slcf_pkg::t_desc r_mem [slcf_pkg::QUEUE_DEPTH];
    logic [slcf_pkg::QUEUE_AW-1:0] r_wptr, n_wptr;
    logic [slcf_pkg::QUEUE_AW-1:0] r_rptr, n_rptr;
    logic [slcf_pkg::QUEUE_AW:0]   r_count, n_count;

    assign o_full  = (r_count == (slcf_pkg::QUEUE_AW+1)'(slcf_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_desc  = r_mem[r_rptr];

    always_comb begin
        n_wptr  = i_wr ? r_wptr + 1'b1 : r_wptr;
        n_rptr  = i_rd ? r_rptr + 1'b1 : r_rptr;
        n_count = r_count + {{slcf_pkg::QUEUE_AW{1'b0}}, i_wr}
                          - {{slcf_pkg::QUEUE_AW{1'b0}}, i_rd};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wptr] <= i_desc;
        end
    end

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n,
        r_count <= (slcf_pkg::QUEUE_AW+1)'(slcf_pkg::QUEUE_DEPTH))
    `ASSERT_IMPLY(a_rd_not_empty, i_clk, i_rst_n, i_rd, !o_empty)

endmodule

`default_nettype wire

// ----- hdl/slcf_front.sv -----
// ----------------------------------------------------------------------------
// slcf_front
// Decodes a display command into a descriptor for the byte sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slcf_front #(
    parameter int LINE_CHARS = 16
) (
    input  wire logic           i_push,
    input  wire slcf_pkg::t_cmd i_cmd,
    input  wire logic           i_q_full,
    output logic                o_wr,
    output slcf_pkg::t_desc     o_desc
);

    localparam logic [7:0] LC8  = 8'(LINE_CHARS);
    localparam logic [7:0] LC8X2 = 8'(2 * LINE_CHARS);

    logic [7:0] cursor;
    logic [7:0] line_base;

    assign o_wr = i_push && !i_q_full;

    always_comb begin
        if (i_cmd.value < LC8) begin
            cursor = slcf_pkg::CURSOR_BASE + i_cmd.value;
        end else if (i_cmd.value < LC8X2) begin
            cursor = slcf_pkg::LINE2_BASE + (i_cmd.value - LC8);
        end else begin
            cursor = slcf_pkg::CURSOR_BASE;
        end
        line_base = (i_cmd.value == slcf_pkg::LINE2_NUM) ? slcf_pkg::LINE2_BASE
                                                         : slcf_pkg::CURSOR_BASE;
    end

    always_comb begin
        unique case (i_cmd.op)
            slcf_pkg::OP_PRINT: begin
                o_desc = '{has_prefix: 1'b0, spaces: 1'b0, byte2: i_cmd.value};
            end
            slcf_pkg::OP_GOTO: begin
                o_desc = '{has_prefix: 1'b1, spaces: 1'b0, byte2: cursor};
            end
            slcf_pkg::OP_CLEAR: begin
                o_desc = '{has_prefix: 1'b1, spaces: 1'b0, byte2: slcf_pkg::CLEAR_CODE};
            end
            slcf_pkg::OP_CLEAR_LINE: begin
                o_desc = '{has_prefix: 1'b1, spaces: 1'b1, byte2: line_base};
            end
            default: begin
                o_desc = '{has_prefix: 1'b0, spaces: 1'b0, byte2: i_cmd.value};
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/slcf_back.sv -----
// ----------------------------------------------------------------------------
// slcf_back
// Byte sequencer: walks a descriptor and emits one framed byte per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module slcf_back #(
    parameter int LINE_CHARS = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_q_empty,
    input  wire slcf_pkg::t_desc i_desc,
    output logic                 o_rd,
    output logic                 o_empty,
    input  wire logic            i_pop,
    output slcf_pkg::t_result    o_result
);

    localparam int CNT_W = $clog2(LINE_CHARS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LINE_CHARS - 1);

    slcf_pkg::t_step   r_step, n_step;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    slcf_pkg::t_result r_out;
    logic              r_out_valid, n_out_valid;

    logic       q_valid;
    logic       adv;
    logic       go;
    logic       cnt_last;
    logic [7:0] sel_byte;
    logic       sel_last;
    logic       sel_deq;

    assign q_valid  = !i_q_empty;
    assign adv      = !r_out_valid || i_pop;
    assign go       = adv && q_valid;
    assign cnt_last = (r_cnt == CNT_LAST);

    // next state
    always_comb begin
        n_step = r_step;
        n_cnt  = r_cnt;
        if (go) begin
            unique case (r_step)
                slcf_pkg::ST_PREFIX: begin
                    if (i_desc.has_prefix) begin
                        n_step = slcf_pkg::ST_BYTE;
                    end else if (i_desc.spaces) begin
                        n_step = slcf_pkg::ST_SPACE;
                        n_cnt  = '0;
                    end
                end
                slcf_pkg::ST_BYTE: begin
                    if (i_desc.spaces) begin
                        n_step = slcf_pkg::ST_SPACE;
                        n_cnt  = '0;
                    end else begin
                        n_step = slcf_pkg::ST_PREFIX;
                    end
                end
                slcf_pkg::ST_SPACE: begin
                    if (cnt_last) begin
                        n_step = slcf_pkg::ST_PREFIX;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
                default: begin
                    n_step = slcf_pkg::ST_PREFIX;
                end
            endcase
        end
    end

    // outputs of the current step
    always_comb begin
        unique case (r_step)
            slcf_pkg::ST_PREFIX: begin
                if (i_desc.has_prefix) begin
                    sel_byte = slcf_pkg::CMD_PREFIX;
                    sel_last = 1'b0;
                    sel_deq  = 1'b0;
                end else begin
                    sel_byte = i_desc.byte2;
                    sel_last = !i_desc.spaces;
                    sel_deq  = !i_desc.spaces;
                end
            end
            slcf_pkg::ST_BYTE: begin
                sel_byte = i_desc.byte2;
                sel_last = !i_desc.spaces;
                sel_deq  = !i_desc.spaces;
            end
            slcf_pkg::ST_SPACE: begin
                sel_byte = slcf_pkg::SPACE_CHAR;
                sel_last = cnt_last;
                sel_deq  = cnt_last;
            end
            default: begin
                sel_byte = slcf_pkg::SPACE_CHAR;
                sel_last = 1'b0;
                sel_deq  = 1'b0;
            end
        endcase
    end

    assign o_rd        = go && sel_deq;
    assign n_out_valid = go || (r_out_valid && !i_pop);
    assign o_empty     = !r_out_valid;
    assign o_result    = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= slcf_pkg::ST_PREFIX;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // load the output register whenever a new beat is produced
    always_ff @(posedge i_clk) begin
        if (go) begin
            r_out <= slcf_pkg::make_result(sel_byte, sel_last);
        end
    end

    `ASSERT_IMPLY(a_mid_cmd_has_desc, i_clk, i_rst_n,
        r_step != slcf_pkg::ST_PREFIX, q_valid)
    `ASSERT_IMPLY(a_space_needs_flag, i_clk, i_rst_n,
        r_step == slcf_pkg::ST_SPACE, i_desc.spaces)
    `ASSERT_IMPLY(a_cnt_in_line, i_clk, i_rst_n,
        r_step == slcf_pkg::ST_SPACE, r_cnt <= CNT_LAST)

endmodule

`default_nettype wire

// ----- hdl/serial_lcd_command_framer.sv -----
// ----------------------------------------------------------------------------
// serial_lcd_command_framer
// Expands display commands into serial LCD bytes with UART 8N1 framing.
// ----------------------------------------------------------------------------
// A command is accepted on any cycle in which the descriptor queue (four
// entries) has room, and the block emits one byte per cycle on the result
// side while pop is held and the queue has work. Print emits one byte,
// go-to-position and clear emit two, and clear-line emits LINE_CHARS + 2.
// The back-end byte sequencer sets the sustained rate; a stream of print
// commands runs at one per cycle while pop is held. A command's first byte
// passes the queue, then the output register. No state survives a command.
`timescale 1ns / 1ps
`default_nettype none

module serial_lcd_command_framer #(
    parameter int LINE_CHARS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire slcf_pkg::t_cmd     i_cmd,
    output logic                    empty,
    input  wire logic               pop,
    output slcf_pkg::t_result       o_result
);

    logic            q_wr;
    logic            q_rd;
    logic            q_full;
    logic            q_empty;
    slcf_pkg::t_desc wr_desc;
    slcf_pkg::t_desc head_desc;

    assign full = q_full;

    slcf_front #(
        .LINE_CHARS (LINE_CHARS)
    ) u_front (
        .i_push   (push),
        .i_cmd    (i_cmd),
        .i_q_full (q_full),
        .o_wr     (q_wr),
        .o_desc   (wr_desc)
    );

    slcf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_desc  (wr_desc),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_empty (q_empty),
        .o_desc  (head_desc)
    );

    slcf_back #(
        .LINE_CHARS (LINE_CHARS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_desc    (head_desc),
        .o_rd      (q_rd),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_result  (o_result)
    );

endmodule

`default_nettype wire
